// ----- hw/rtl/rbc_pkg.sv -----
package rbc_pkg;

    localparam int CMD_W = 2;
    localparam int CAP_W = 13;
    localparam int LIM_W = 7;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    // Input item
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [7:0]       data_byte;
        logic [63:0]      cursor;
        logic [LIM_W-1:0] max_bytes;
    } t_rbc_in;

    // Result item
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_data;
        logic        cursor_lost;
        logic [63:0] available_from;
        logic [63:0] next_cursor;
        logic [63:0] total_produced;
        logic        truncated;
        logic        last;
    } t_rbc_out;

    // Queue entry between front and back: classified command with its
    // saturated read limit and the capacity in force when it was accepted
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [7:0]       data_byte;
        logic [63:0]      cursor;
        logic [LIM_W-1:0] limit;
        logic [CAP_W-1:0] cap;
    } t_rbc_cmd;

endpackage

// ----- hw/rtl/rbc_front.sv -----
module rbc_front #(
    parameter int MAX_CHUNK = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  rbc_pkg::t_rbc_in          i_in_item,
    input  logic                      i_cfg_we,
    input  logic [rbc_pkg::CAP_W-1:0] i_cfg_wdata,
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output rbc_pkg::t_rbc_cmd         o_q_item
);
    import rbc_pkg::*;

    logic [CAP_W-1:0] r_cap;
    logic             known;
    logic [LIM_W-1:0] lim;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Command decode: unused code is taken and dropped
    always_comb begin
        unique case (i_in_item.cmd) inside
            CMD_APPEND, CMD_READ, CMD_CLEAR: known = 1'b1;
            default:                         known = 1'b0;
        endcase
    end

    // Read limit: zero or oversize means a full chunk
    always_comb begin
        if (i_in_item.max_bytes == '0 || i_in_item.max_bytes > LIM_W'(MAX_CHUNK)) begin
            lim = LIM_W'(MAX_CHUNK);
        end else begin
            lim = i_in_item.max_bytes;
        end
    end

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full && known;

    always_comb begin
        o_q_item.cmd       = i_in_item.cmd;
        o_q_item.data_byte = i_in_item.data_byte;
        o_q_item.cursor    = i_in_item.cursor;
        o_q_item.limit     = lim;
        o_q_item.cap       = r_cap;
    end

endmodule

// ----- hw/rtl/rbc_queue.sv -----
module rbc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rbc_pkg::t_rbc_cmd i_item,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output rbc_pkg::t_rbc_cmd o_item
);
    import rbc_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    t_rbc_cmd       r_q [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_item;
        end
    end

endmodule

// ----- hw/rtl/rbc_back.sv -----
module rbc_back #(
    parameter int DEPTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    output logic              o_q_pop,
    input  rbc_pkg::t_rbc_cmd i_q_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rbc_pkg::t_rbc_out o_out_item
);
    import rbc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int XW = (FW > CAP_W) ? FW : CAP_W;
    localparam int NW = (FW > LIM_W) ? FW : LIM_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LEN  = 2'd1;
    localparam logic [1:0] S_ADDR = 2'd2;
    localparam logic [1:0] S_RUN  = 2'd3;

    // Zero or oversize capacity means the whole store
    function automatic logic [FW-1:0] eff_cap(input logic [CAP_W-1:0] c);
        if (c == '0 || XW'(c) > XW'(DEPTH)) begin
            return FW'(DEPTH);
        end
        return FW'(c);
    endfunction

    logic [1:0]       r_state;
    logic [63:0]      r_total;
    logic [63:0]      r_head;
    logic             r_trunc;
    logic [FW-1:0]    r_fill;
    logic [AW-1:0]    r_wptr;
    logic [7:0]       r_mem [DEPTH];
    logic [7:0]       r_rdata;

    logic             r_empty;
    logic             r_lost;
    logic [63:0]      r_pos;
    logic [FW-1:0]    r_rem;
    logic [LIM_W-1:0] r_lim;
    logic [LIM_W-1:0] r_left;
    logic [AW-1:0]    r_raddr;

    logic             r_inf_valid;
    t_rbc_out         r_inf;

    t_rbc_out         r_oq [2];
    logic             r_owr;
    logic             r_ord;
    logic [1:0]       r_ocnt;

    logic             q_pop;
    logic             out_pop;
    logic             out_push;
    logic             room;
    logic             issue;
    logic             empty_push;
    logic [FW-1:0]    app_cap;
    logic             drop;
    logic [AW-1:0]    wptr_inc;
    logic [FW-1:0]    wext;
    logic [FW-1:0]    n_start;
    logic [AW-1:0]    n_raddr;
    logic [LIM_W-1:0] n_left;
    t_rbc_out         push_item;

    // Handshake and credit for the two-entry output queue
    assign q_pop       = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop     = q_pop;
    assign o_out_valid = (r_ocnt != 2'd0);
    assign o_out_item  = r_oq[r_ord];
    assign out_pop     = o_out_valid && i_out_ready;
    assign room        = ((3'(r_ocnt) + 3'(r_inf_valid) - 3'(out_pop)) < 3'd2);
    assign issue       = (r_state == S_RUN) && room;
    assign empty_push  = (r_state == S_LEN) && r_empty && room && !r_inf_valid;
    assign out_push    = r_inf_valid || empty_push;

    // Append bookkeeping
    assign app_cap  = eff_cap(i_q_item.cap);
    assign drop     = (r_fill >= app_cap);
    assign wptr_inc = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);

    // Ring address of the first byte: write pointer minus bytes remaining
    always_comb begin
        wext = FW'(r_wptr);
        if (wext >= r_rem) begin
            n_start = wext - r_rem;
        end else begin
            n_start = wext + FW'(DEPTH) - r_rem;
        end
        n_raddr = AW'(n_start);
    end

    // Byte count of this read
    assign n_left = (NW'(r_rem) < NW'(r_lim)) ? LIM_W'(r_rem) : r_lim;

    // Result to queue: read byte, else the empty answer
    always_comb begin
        if (r_inf_valid) begin
            push_item          = r_inf;
            push_item.out_byte = r_rdata;
        end else begin
            push_item.out_byte       = 8'd0;
            push_item.has_data       = 1'b0;
            push_item.cursor_lost    = 1'b0;
            push_item.available_from = r_head;
            push_item.next_cursor    = r_total;
            push_item.total_produced = r_total;
            push_item.truncated      = r_trunc;
            push_item.last           = 1'b1;
        end
    end

    // Sequencer and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_head      <= '0;
            r_trunc     <= 1'b0;
            r_fill      <= '0;
            r_wptr      <= '0;
            r_inf_valid <= 1'b0;
            r_owr       <= 1'b0;
            r_ord       <= 1'b0;
            r_ocnt      <= 2'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (q_pop) begin
                        unique case (i_q_item.cmd)
                            CMD_APPEND: begin
                                r_wptr  <= wptr_inc;
                                r_total <= r_total + 64'd1;
                                if (drop) begin
                                    r_head  <= r_total - 64'(app_cap - FW'(1));
                                    r_fill  <= app_cap;
                                    r_trunc <= 1'b1;
                                end else begin
                                    r_fill <= r_fill + FW'(1);
                                end
                            end
                            CMD_CLEAR: begin
                                r_total <= '0;
                                r_head  <= '0;
                                r_trunc <= 1'b0;
                                r_fill  <= '0;
                                r_wptr  <= '0;
                            end
                            CMD_READ: begin
                                r_state <= S_LEN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_LEN: begin
                    if (!r_empty) begin
                        r_state <= S_ADDR;
                    end else if (empty_push) begin
                        r_state <= S_IDLE;
                    end
                end
                S_ADDR: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (issue && r_left == LIM_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            r_inf_valid <= issue;

            if (out_push) begin
                r_owr <= ~r_owr;
            end
            if (out_pop) begin
                r_ord <= ~r_ord;
            end
            r_ocnt <= r_ocnt + 2'(out_push) - 2'(out_pop);
        end
    end

    // Read setup and per-byte datapath
    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_empty <= (i_q_item.cursor >= r_total);
            r_lost  <= (i_q_item.cursor < r_head);
            r_pos   <= (i_q_item.cursor < r_head) ? r_head : i_q_item.cursor;
            r_lim   <= i_q_item.limit;
        end
        if (r_state == S_LEN) begin
            r_rem <= FW'(r_total - r_pos);
        end
        if (r_state == S_ADDR) begin
            r_raddr <= n_raddr;
            r_left  <= n_left;
        end
        if (issue) begin
            r_raddr              <= (r_raddr == AW'(DEPTH - 1)) ? '0 : r_raddr + AW'(1);
            r_pos                <= r_pos + 64'd1;
            r_left               <= r_left - LIM_W'(1);
            r_inf.out_byte       <= 8'd0;
            r_inf.has_data       <= 1'b1;
            r_inf.cursor_lost    <= r_lost;
            r_inf.available_from <= r_head;
            r_inf.next_cursor    <= r_pos + 64'd1;
            r_inf.total_produced <= r_total;
            r_inf.truncated      <= r_trunc;
            r_inf.last           <= (r_left == LIM_W'(1));
        end
    end

    // Byte store: write on append, registered read on issue
    always_ff @(posedge i_clk) begin
        if (q_pop && i_q_item.cmd == CMD_APPEND) begin
            r_mem[r_wptr] <= i_q_item.data_byte;
        end
        if (issue) begin
            r_rdata <= r_mem[r_raddr];
        end
    end

    // Output queue storage
    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_oq[r_owr] <= push_item;
        end
    end

    // Checks
    a_ocnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 2'd2)
        else $error("output queue overfilled");

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("window fill beyond store depth");

    a_inflight_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inf_valid |-> (r_ocnt != 2'd2 || out_pop))
        else $error("read data arrived with no output slot");

    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_left != '0))
        else $error("read sequencer running with zero bytes left");

    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && i_q_item.cmd == CMD_CLEAR) |=>
            (r_total == '0 && r_fill == '0 && !r_trunc))
        else $error("clear did not empty the window");

endmodule

// ----- hw/rtl/overwriting_byte_ring_with_cursors_top.sv -----
// Overwriting byte ring with absolute stream cursors.
// Input channel (valid/ready) carries commands: append one byte, read from
// an absolute cursor with a byte limit, or clear. Unused command codes are
// taken and dropped. Output channel (valid/ready) carries one item per byte
// read, or a single empty item when the cursor is at or past the total.
// Config: i_cfg_we/i_cfg_wdata write the capacity; each command carries the
// capacity current when it was accepted.
// An append is registered in the command queue and updates the window when
// the back end dequeues it. A read holds the back end for dequeue, length and
// start address setup, then one registered store read per byte, giving one
// byte per cycle while the output queue has room; an empty read holds it for
// dequeue and length. Throughput: one append per cycle while no read is busy.
// Reset: counters, head and truncated flag clear, capacity returns to 4096;
// store contents stay undefined and no clearing pass runs.
// Receiver stall: a two-entry output queue absorbs in-flight bytes, the read
// sequencer pauses, and the two-entry command queue fills before the input
// channel drops ready.
module overwriting_byte_ring_with_cursors_top #(
    parameter int DEPTH     = 4096,
    parameter int MAX_CHUNK = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  rbc_pkg::t_rbc_in          i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output rbc_pkg::t_rbc_out         o_out_item,
    input  logic                      i_cfg_we,
    input  logic [rbc_pkg::CAP_W-1:0] i_cfg_wdata
);
    import rbc_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    t_rbc_cmd q_in;
    t_rbc_cmd q_out;

    // Accept and classify
    rbc_front #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_item    (q_in)
    );

    // Command queue
    rbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_out)
    );

    // Window state, byte store and read sequencer
    rbc_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_item    (q_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
